@@ design/thermostat_with_moving_average_defines.svh @@
// assertion macros for the thermostat block
`ifndef THERMOSTAT_WITH_MOVING_AVERAGE_DEFINES_SVH
`define THERMOSTAT_WITH_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication
`define TWMA_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TWMA_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/twma_pkg.sv @@
// shared types and constants of the thermostat block
package twma_pkg;

  localparam int WINDOW_SIZE_DEF = 10;
  localparam int SETPOINT_STEP   = 5;

  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] SAVED_NONE = 8'hFF;

  localparam logic [7:0] MARGIN_RST      = 8'd2;
  localparam logic [7:0] MIN_SP_RST      = 8'd35;
  localparam logic [7:0] MAX_SP_RST      = 8'd75;
  localparam logic [7:0] DEFAULT_SP_RST  = 8'd60;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SP = 3'd3;

  typedef enum logic [1:0] {
    REQ_INIT    = 2'd0,
    REQ_ON      = 2'd1,
    REQ_SETTING = 2'd2,
    REQ_OFF     = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SUM    = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

@@ design/thermostat_with_moving_average.sv @@
// thermostat with moving-average window, serial sum and reciprocal divide
//
//  channel | signals                               | dir
//  in      | in_valid in_ready + item fields       | into block
//  out     | out_valid out_ready + result fields   | out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data| into block
//
//  on-mode item with a sample: accept, one shared adder over the window, one
//  reciprocal multiply, result load; any other item goes from accept straight to
//  result load; next item taken as soon as the sequencer is idle
//  a result waits in the output register while out_ready is low; the sequencer
//  then holds in its last state until the register frees
//  synchronous reset clears control, drive levels, setpoint, mean and out_valid, and loads config defaults
`include "thermostat_with_moving_average_defines.svh"

module thermostat_with_moving_average
  import twma_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  logic                 sample_valid,
  input  logic [7:0]           sample,
  input  logic [7:0]           saved_setpoint,
  input  logic                 up_pressed,
  input  logic                 down_pressed,
  input  logic                 blink_on,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 heater_on,
  output logic                 cooler_on,
  output logic                 led_on,
  output logic                 display_on,
  output logic [7:0]           display_value,
  output logic                 enter_setting,
  output logic                 setting_activity,
  output logic [7:0]           setpoint_out,
  output logic [7:0]           mean_temp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int SUM_W = 8 + $clog2(WINDOW_SIZE + 1);
  localparam int DIV_SH = $clog2(WINDOW_SIZE);
  localparam int RECIP_SH = SUM_W + DIV_SH;
  localparam int RECIP_W = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SH) + WINDOW_SIZE - 1) / WINDOW_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);

  logic [7:0] margin, min_setpoint, max_setpoint, default_setpoint;

  logic [7:0]       window [WINDOW_SIZE];
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       mean_value;
  logic [7:0]       last_sample;
  logic [7:0]       setpoint;

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic [SUM_W-1:0] acc;

  req_t req_q;
  logic up_q, down_q, blink_q;

  logic in_acc, load;

  // result of the current item
  logic       r_heater, r_cooler, r_led, r_disp_on, r_enter, r_activity;
  logic [7:0] r_disp_val, r_setpoint;

  logic signed [9:0] lo, hi, sp_s;
  logic [8:0]        sp_up;
  logic [7:0]        sp1;
  logic              act1, act2;

  logic [SUM_W+RECIP_W-1:0] quot_full;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign load      = (state == ST_FINISH) & (~out_valid | out_ready);

  // window sum over size by reciprocal multiply, exact for every sum
  assign quot_full = acc * RECIP;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      margin           <= MARGIN_RST;
      min_setpoint     <= MIN_SP_RST;
      max_setpoint     <= MAX_SP_RST;
      default_setpoint <= DEFAULT_SP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MARGIN:     margin           <= cfg_data;
        CFG_MIN_SP:     min_setpoint     <= cfg_data;
        CFG_MAX_SP:     max_setpoint     <= cfg_data;
        CFG_DEFAULT_SP: default_setpoint <= cfg_data;
        default: ;
      endcase
    end
  end

  // window store, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (req_t'(req_type) == REQ_INIT) begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
          window[i] <= sample;
        end
      end else if (req_t'(req_type) == REQ_ON && sample_valid) begin
        window[wr_idx] <= sample;
      end
    end
  end

  // latched item controls
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_q   <= req_t'(req_type);
      up_q    <= up_pressed;
      down_q  <= down_pressed;
      blink_q <= blink_on;
    end
  end

  // result logic
  always_comb begin
    lo   = signed'({2'b00, mean_value}) - signed'({2'b00, margin});
    hi   = signed'({2'b00, mean_value}) + signed'({2'b00, margin});
    sp_s = signed'({2'b00, setpoint});

    sp_up = {1'b0, setpoint} + 9'(SETPOINT_STEP);
    act1  = up_q && (setpoint < max_setpoint);
    sp1   = act1 ? (sp_up[8] ? 8'hFF : sp_up[7:0]) : setpoint;
    act2  = down_q && (sp1 > min_setpoint);

    r_heater   = 1'b0;
    r_cooler   = 1'b0;
    r_led      = 1'b0;
    r_disp_on  = 1'b0;
    r_disp_val = 8'd0;
    r_enter    = 1'b0;
    r_activity = 1'b0;
    r_setpoint = setpoint;

    unique case (req_q)
      REQ_ON: begin
        r_disp_on  = ~(up_q | down_q);
        r_disp_val = last_sample;
        r_enter    = up_q | down_q;
        priority if (sp_s < hi && sp_s > lo) begin
          r_heater = 1'b0;
          r_cooler = 1'b0;
          r_led    = 1'b0;
        end else if (sp_s < hi) begin
          r_cooler = 1'b1;
          r_led    = 1'b1;
        end else if (sp_s > lo) begin
          r_heater = 1'b1;
          r_led    = blink_q;
        end else begin
          r_heater = heater_on;
          r_cooler = cooler_on;
          r_led    = led_on;
        end
      end
      REQ_SETTING: begin
        r_setpoint = act2 ? ((sp1 > 8'(SETPOINT_STEP)) ? sp1 - 8'(SETPOINT_STEP) : 8'd0)
                          : sp1;
        r_activity = act1 | act2;
        r_disp_on  = blink_q | act1 | act2;
        r_disp_val = r_setpoint;
      end
      REQ_INIT, REQ_OFF: ;
      default: ;
    endcase
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      wr_idx      <= '0;
      mean_value  <= 8'd0;
      last_sample <= 8'd0;
      setpoint    <= 8'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cnt <= '0;
            acc <= '0;
            priority if (req_t'(req_type) == REQ_INIT) begin
              setpoint   <= (saved_setpoint != SAVED_NONE) ? saved_setpoint
                                                           : default_setpoint;
              mean_value <= sample;
              wr_idx     <= '0;
              state      <= ST_FINISH;
            end else if (req_t'(req_type) == REQ_ON && sample_valid) begin
              last_sample <= sample;
              wr_idx      <= (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
              state       <= ST_SUM;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SUM: begin
          acc <= acc + SUM_W'(window[cnt]);
          if (cnt == IDX_LAST) begin
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          mean_value <= quot_full[RECIP_SH +: 8];
          state      <= ST_FINISH;
        end
        ST_FINISH: begin
          if (load) begin
            setpoint <= r_setpoint;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register; drive levels live here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      heater_on <= 1'b0;
      cooler_on <= 1'b0;
      led_on    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        heater_on <= r_heater;
        cooler_on <= r_cooler;
        led_on    <= r_led;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      display_on       <= r_disp_on;
      display_value    <= r_disp_val;
      enter_setting    <= r_enter;
      setting_activity <= r_activity;
      setpoint_out     <= r_setpoint;
      mean_temp        <= mean_value;
    end
  end

  `TWMA_ASSERT_IMP(a_idx_range, clk, rst, 1'b1, {1'b0, wr_idx} < (IDX_W + 1)'(WINDOW_SIZE), "write index out of window")
  `TWMA_ASSERT_NXT(a_sample_sums, clk, rst, in_acc && req_t'(req_type) == REQ_ON && sample_valid, state == ST_SUM, "new sample did not start summing")
  `TWMA_ASSERT_NXT(a_load_done, clk, rst, load, out_valid && state == ST_IDLE, "result load did not finish the item")
  `TWMA_ASSERT_NXT(a_init_off, clk, rst, load && req_q == REQ_INIT, !heater_on && !cooler_on && !led_on, "drives not off after init")

endmodule
